// ===== src/fatlb_pkg.sv =====
// ----------------------------------------------------------------------------
// fatlb_pkg
// Shared sizes, operation codes and the search result type of the
// fully associative translation buffer.
// ----------------------------------------------------------------------------
`default_nettype none

package fatlb_pkg;

   localparam int TLB_SLOTS   = 8;
   localparam int OFFSET_BITS = 12;
   localparam int FRAME_BITS  = 8;

   localparam int IDX_W      = (TLB_SLOTS > 1) ? $clog2(TLB_SLOTS) : 1;
   localparam int VA_W       = 32;
   localparam int PAGE_W     = 20;
   localparam int FRAME_W    = 8;
   localparam int PA_W       = 20;
   localparam int LFSR_W     = 16;
   localparam int NIBBLES    = LFSR_W / 4;

   localparam logic [LFSR_W-1:0]  LFSR_SEED   = 16'hACE1;
   localparam logic [FRAME_W-1:0] FRAME_MASK  = FRAME_W'((64'd1 << FRAME_BITS) - 64'd1);
   localparam logic [VA_W-1:0]    OFFSET_MASK = VA_W'((64'd1 << OFFSET_BITS) - 64'd1);

   typedef enum logic [1:0] {
      OP_LOOKUP = 2'd0,
      OP_FILL   = 2'd1,
      OP_FLUSH  = 2'd2
   } op_type;

   typedef struct packed {
      logic             look_hit;
      logic [IDX_W-1:0] look_idx;
      logic             frame_hit;
      logic [IDX_W-1:0] frame_idx;
      logic             free_hit;
      logic [IDX_W-1:0] free_idx;
   } search_type;

endpackage

`default_nettype wire

// ===== src/fatlb_search.sv =====
// ----------------------------------------------------------------------------
// fatlb_search
// Parallel compare of all entries: lowest matching page, lowest valid
// entry with the fill frame, and lowest free entry.
// ----------------------------------------------------------------------------
`default_nettype none

module fatlb_search (
   input  wire logic [fatlb_pkg::TLB_SLOTS-1:0] entry_valid,
   input  wire logic [fatlb_pkg::PAGE_W-1:0]    entry_page  [fatlb_pkg::TLB_SLOTS],
   input  wire logic [fatlb_pkg::FRAME_W-1:0]   entry_frame [fatlb_pkg::TLB_SLOTS],
   input  wire logic                            look_fits,
   input  wire logic [fatlb_pkg::PAGE_W-1:0]    look_page,
   input  wire logic [fatlb_pkg::FRAME_W-1:0]   fill_frame,
   output fatlb_pkg::search_type                found
);

   // walk from the top so the lowest index wins
   always_comb begin
      found = '0;
      for (int i = fatlb_pkg::TLB_SLOTS - 1; i >= 0; i--) begin
         if (entry_valid[i] && look_fits && entry_page[i] == look_page) begin
            found.look_hit = 1'b1;
            found.look_idx = fatlb_pkg::IDX_W'(i);
         end
         if (entry_valid[i] && entry_frame[i] == fill_frame) begin
            found.frame_hit = 1'b1;
            found.frame_idx = fatlb_pkg::IDX_W'(i);
         end
         if (!entry_valid[i]) begin
            found.free_hit = 1'b1;
            found.free_idx = fatlb_pkg::IDX_W'(i);
         end
      end
   end

endmodule

`default_nettype wire

// ===== src/fully_associative_tlb.sv =====
// ----------------------------------------------------------------------------
// fully_associative_tlb
// Fully associative translation buffer with lookup, fill and flush and
// LFSR-driven victim choice when every entry is in use.
// ----------------------------------------------------------------------------
// Usage:
//   A word is taken at a clock edge with start high and busy low. It
//   carries an operation (lookup, fill, flush) and its operands.
//   Every word gives exactly one result word on rsp_hit and
//   rsp_physical_address, marked by rsp_valid for one cycle. Fill, flush
//   and the unused code give hit low and address zero.
//   The word is registered in the input register at its accept edge, the
//   search runs in the next cycle, and the entry update and the result
//   word are written into the entries and the result register together.
//   Throughput: one word per cycle; busy stays low once out of reset.
//   Each word sees the entry state left by the word before it.
//   Reset clears all valid bits, loads the LFSR seed and holds busy
//   high until the cycle after reset drops. The receiver cannot stall:
//   results are presented once and never held.
// ----------------------------------------------------------------------------
`default_nettype none

module fully_associative_tlb (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            start,
   output logic                                 busy,
   input  wire logic [1:0]                      req_operation,
   input  wire logic [fatlb_pkg::VA_W-1:0]      req_virtual_address,
   input  wire logic [fatlb_pkg::PAGE_W-1:0]    req_fill_page,
   input  wire logic [fatlb_pkg::FRAME_W-1:0]   req_fill_frame,
   input  wire logic                            req_write_access,
   output logic                                 rsp_valid,
   output logic                                 rsp_hit,
   output logic [fatlb_pkg::PA_W-1:0]           rsp_physical_address
);

   localparam int S    = fatlb_pkg::TLB_SLOTS;
   localparam int IW   = fatlb_pkg::IDX_W;
   localparam int SUMW = 8;

   // input register
   logic                          busy_ff;
   logic                          req_valid_ff;
   logic [1:0]                    req_op_ff;
   logic [fatlb_pkg::VA_W-1:0]    req_va_ff;
   logic [fatlb_pkg::PAGE_W-1:0]  req_page_ff;
   logic [fatlb_pkg::FRAME_W-1:0] req_frame_ff;
   logic                          req_acc_ff;

   // entries
   logic [S-1:0]                  valid_ff, valid_in;
   logic [fatlb_pkg::PAGE_W-1:0]  page_ff  [S];
   logic [fatlb_pkg::FRAME_W-1:0] frame_ff [S];
   logic [S-1:0]                  access_ff;
   logic [fatlb_pkg::LFSR_W-1:0]  lfsr_ff, lfsr_in;

   // result register
   logic                          rsp_valid_ff;
   logic                          rsp_hit_ff, rsp_hit_in;
   logic [fatlb_pkg::PA_W-1:0]    rsp_pa_ff, rsp_pa_in;

   logic                          accept;
   logic [fatlb_pkg::VA_W-1:0]    va_page;
   logic                          look_fits;
   logic [fatlb_pkg::VA_W-1:0]    va_offset;
   fatlb_pkg::search_type         found;

   logic [fatlb_pkg::LFSR_W-1:0]  lfsr_step;
   logic [IW-1:0]                 mod_lut [fatlb_pkg::NIBBLES][16];
   logic [SUMW-1:0]               mod_sum;
   logic [IW-1:0]                 victim_idx;

   logic                          wr_en;
   logic [IW-1:0]                 wr_idx;
   logic                          acc_en;
   logic [IW-1:0]                 acc_idx;
   logic                          flush_all;

   assign accept = start && !busy_ff;
   assign busy   = busy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b1;
         req_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= 1'b0;
         req_valid_ff <= accept;
      end
      if (accept) begin
         req_op_ff    <= req_operation;
         req_va_ff    <= req_virtual_address;
         req_page_ff  <= req_fill_page;
         req_frame_ff <= req_fill_frame & fatlb_pkg::FRAME_MASK;
         req_acc_ff   <= req_write_access;
      end
   end

   assign va_page   = req_va_ff >> fatlb_pkg::OFFSET_BITS;
   assign look_fits = (va_page >> fatlb_pkg::PAGE_W) == '0;
   assign va_offset = req_va_ff & fatlb_pkg::OFFSET_MASK;

   fatlb_search u_search (
      .entry_valid (valid_ff),
      .entry_page  (page_ff),
      .entry_frame (frame_ff),
      .look_fits   (look_fits),
      .look_page   (va_page[fatlb_pkg::PAGE_W-1:0]),
      .fill_frame  (req_frame_ff),
      .found       (found)
   );

   // advanced LFSR value and its residue modulo the entry count
   assign lfsr_step = {lfsr_ff[0] ^ lfsr_ff[2] ^ lfsr_ff[3] ^ lfsr_ff[5],
                       lfsr_ff[fatlb_pkg::LFSR_W-1:1]};

   for (genvar k = 0; k < fatlb_pkg::NIBBLES; k++) begin : g_nib
      for (genvar n = 0; n < 16; n++) begin : g_val
         localparam int TERM = ((n << (4 * k)) % fatlb_pkg::TLB_SLOTS);
         assign mod_lut[k][n] = IW'(TERM);
      end
   end

   always_comb begin
      mod_sum = '0;
      for (int k = 0; k < fatlb_pkg::NIBBLES; k++) begin
         mod_sum = mod_sum + SUMW'(mod_lut[k][lfsr_step[4*k +: 4]]);
      end
      // sum of four residues stays below four times the entry count
      if (mod_sum >= SUMW'(3 * S)) begin
         victim_idx = IW'(mod_sum - SUMW'(3 * S));
      end else if (mod_sum >= SUMW'(2 * S)) begin
         victim_idx = IW'(mod_sum - SUMW'(2 * S));
      end else if (mod_sum >= SUMW'(S)) begin
         victim_idx = IW'(mod_sum - SUMW'(S));
      end else begin
         victim_idx = IW'(mod_sum);
      end
   end

   always_comb begin
      wr_en      = 1'b0;
      wr_idx     = '0;
      acc_en     = 1'b0;
      acc_idx    = found.look_idx;
      flush_all  = 1'b0;
      lfsr_in    = lfsr_ff;
      rsp_hit_in = 1'b0;
      rsp_pa_in  = '0;
      if (req_valid_ff) begin
         case (fatlb_pkg::op_type'(req_op_ff))
            fatlb_pkg::OP_LOOKUP: begin
               if (found.look_hit) begin
                  acc_en     = 1'b1;
                  rsp_hit_in = 1'b1;
                  rsp_pa_in  = fatlb_pkg::PA_W'(
                     (fatlb_pkg::VA_W'(frame_ff[found.look_idx]) << fatlb_pkg::OFFSET_BITS)
                     | va_offset);
               end
            end
            fatlb_pkg::OP_FILL: begin
               wr_en = 1'b1;
               if (found.frame_hit) begin
                  wr_idx = found.frame_idx;
               end else if (found.free_hit) begin
                  wr_idx = found.free_idx;
               end else begin
                  wr_idx  = victim_idx;
                  lfsr_in = lfsr_step;
               end
            end
            fatlb_pkg::OP_FLUSH: begin
               flush_all = 1'b1;
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      valid_in = valid_ff;
      if (flush_all) begin
         valid_in = '0;
      end else if (wr_en) begin
         valid_in[wr_idx] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         lfsr_ff      <= fatlb_pkg::LFSR_SEED;
         rsp_valid_ff <= 1'b0;
      end else begin
         valid_ff     <= valid_in;
         lfsr_ff      <= lfsr_in;
         rsp_valid_ff <= req_valid_ff;
      end
      if (wr_en) begin
         page_ff[wr_idx]   <= req_page_ff;
         frame_ff[wr_idx]  <= req_frame_ff;
         access_ff[wr_idx] <= req_acc_ff;
      end else if (acc_en) begin
         access_ff[acc_idx] <= req_acc_ff;
      end
      rsp_hit_ff <= rsp_hit_in;
      rsp_pa_ff  <= rsp_pa_in;
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_hit              = rsp_hit_ff;
   assign rsp_physical_address = rsp_pa_ff;

   // the access bits are kept as entry state; nothing reads them back out
   logic unused_access;
   assign unused_access = ^access_ff;

endmodule

`default_nettype wire

// ===== sim/fatlb_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// fatlb_checker
// Watches the request and result channels of the translation buffer,
// keeps its own copy of the entries and the victim LFSR, predicts the
// result of every accepted word and compares each result word, in order,
// with the oldest prediction.
// ----------------------------------------------------------------------------

module fatlb_checker (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            start,
   input  wire logic                            busy,
   input  wire logic [1:0]                      req_operation,
   input  wire logic [fatlb_pkg::VA_W-1:0]      req_virtual_address,
   input  wire logic [fatlb_pkg::PAGE_W-1:0]    req_fill_page,
   input  wire logic [fatlb_pkg::FRAME_W-1:0]   req_fill_frame,
   input  wire logic                            req_write_access,
   input  wire logic                            rsp_valid,
   input  wire logic                            rsp_hit,
   input  wire logic [fatlb_pkg::PA_W-1:0]      rsp_physical_address,
   output int                                   fail_count,
   output int                                   pending
);

   typedef struct packed {
      logic                       hit;
      logic [fatlb_pkg::PA_W-1:0] paddr;
   } xlat_type;

   logic                          slot_valid  [fatlb_pkg::TLB_SLOTS];
   logic [fatlb_pkg::PAGE_W-1:0]  slot_page   [fatlb_pkg::TLB_SLOTS];
   logic [fatlb_pkg::FRAME_W-1:0] slot_frame  [fatlb_pkg::TLB_SLOTS];
   logic                          slot_access [fatlb_pkg::TLB_SLOTS];
   logic [fatlb_pkg::LFSR_W-1:0]  victim_lfsr;

   xlat_type translations_q[$];
   int       mismatches = 0;

   // Apply one word to the shadow entries and return the translation it yields.
   function automatic xlat_type predict_xlat(input logic [1:0]                    op,
                                             input logic [fatlb_pkg::VA_W-1:0]    va,
                                             input logic [fatlb_pkg::PAGE_W-1:0]  page,
                                             input logic [fatlb_pkg::FRAME_W-1:0] frame_in,
                                             input logic                          acc);
      xlat_type                      r;
      logic [fatlb_pkg::VA_W-1:0]    vpage;
      logic [63:0]                   pa;
      logic [fatlb_pkg::FRAME_W-1:0] frame;
      logic                          fb;
      int                            slot;
      r     = '0;
      frame = frame_in & fatlb_pkg::FRAME_MASK;
      slot  = -1;
      case (op)
         fatlb_pkg::OP_LOOKUP: begin
            vpage = va >> fatlb_pkg::OFFSET_BITS;
            for (int i = 0; i < fatlb_pkg::TLB_SLOTS; i++)
               if (slot < 0 && slot_valid[i] &&
                   fatlb_pkg::VA_W'(slot_page[i]) == vpage)
                  slot = i;
            if (slot >= 0) begin
               pa = (64'(slot_frame[slot]) << fatlb_pkg::OFFSET_BITS)
                    | 64'(va & fatlb_pkg::OFFSET_MASK);
               slot_access[slot] = acc;
               r.hit   = 1'b1;
               r.paddr = pa[fatlb_pkg::PA_W-1:0];
            end
         end
         fatlb_pkg::OP_FILL: begin
            // reuse an entry that already maps this frame
            for (int i = 0; i < fatlb_pkg::TLB_SLOTS; i++)
               if (slot < 0 && slot_valid[i] && slot_frame[i] == frame)
                  slot = i;
            if (slot >= 0) begin
               slot_page[slot]   = page;
               slot_access[slot] = acc;
            end else begin
               for (int i = 0; i < fatlb_pkg::TLB_SLOTS; i++)
                  if (slot < 0 && !slot_valid[i])
                     slot = i;
               if (slot < 0) begin
                  // advance the LFSR only when every entry is taken
                  fb = victim_lfsr[0] ^ victim_lfsr[2] ^ victim_lfsr[3] ^ victim_lfsr[5];
                  victim_lfsr = {fb, victim_lfsr[fatlb_pkg::LFSR_W-1:1]};
                  slot = int'(victim_lfsr % fatlb_pkg::TLB_SLOTS);
               end
               slot_valid[slot]  = 1'b1;
               slot_page[slot]   = page;
               slot_frame[slot]  = frame;
               slot_access[slot] = acc;
            end
         end
         fatlb_pkg::OP_FLUSH: begin
            for (int i = 0; i < fatlb_pkg::TLB_SLOTS; i++)
               slot_valid[i] = 1'b0;
         end
         default: ;
      endcase
      return r;
   endfunction

   always @(posedge clock) begin : watch
      xlat_type want;
      if (reset) begin
         for (int i = 0; i < fatlb_pkg::TLB_SLOTS; i++) begin
            slot_valid[i]  = 1'b0;
            slot_page[i]   = '0;
            slot_frame[i]  = '0;
            slot_access[i] = 1'b0;
         end
         victim_lfsr = fatlb_pkg::LFSR_SEED;
         translations_q.delete();
      end else begin
         if (rsp_valid) begin
            if (translations_q.size() == 0) begin
               if (mismatches < 10)
                  $display("%0t: result word with nothing expected: hit %b addr %05h",
                           $time, rsp_hit, rsp_physical_address);
               mismatches++;
            end else begin
               want = translations_q.pop_front();
               if (want.hit !== rsp_hit || want.paddr !== rsp_physical_address) begin
                  if (mismatches < 10)
                     $display("%0t: mismatch: hit exp %b got %b, addr exp %05h got %05h",
                              $time, want.hit, rsp_hit, want.paddr, rsp_physical_address);
                  mismatches++;
               end
            end
         end
         if (start && !busy)
            translations_q.push_back(predict_xlat(req_operation, req_virtual_address,
                                                  req_fill_page, req_fill_frame,
                                                  req_write_access));
      end
      fail_count <= mismatches;
      pending    <= translations_q.size();
   end

endmodule

// ===== sim/fully_associative_tlb_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// fully_associative_tlb_tb
// Drives lookup, fill and flush words into the translation buffer: a
// directed opening over hits, misses, frame reuse, duplicate pages,
// random victims, flush and the unused code, then bursts of random words
// built around a small pool of pages and frames so that entries are hit,
// reused and evicted. A checker beside the block predicts and compares.
// ----------------------------------------------------------------------------

module fully_associative_tlb_tb;

   localparam int RANDOM_WORDS = 650;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int POOL_SIZE    = 16;
   localparam logic [1:0] OP_UNUSED = 2'd3;

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            start = 1'b0;
   logic                            busy;
   logic [1:0]                      req_operation       = '0;
   logic [fatlb_pkg::VA_W-1:0]      req_virtual_address = '0;
   logic [fatlb_pkg::PAGE_W-1:0]    req_fill_page       = '0;
   logic [fatlb_pkg::FRAME_W-1:0]   req_fill_frame      = '0;
   logic                            req_write_access    = 1'b0;
   logic                            rsp_valid;
   logic                            rsp_hit;
   logic [fatlb_pkg::PA_W-1:0]      rsp_physical_address;
   int                              fail_count;
   int                              pending;
   int                              cycle_count = 0;
   logic [fatlb_pkg::PAGE_W-1:0]    page_pool [POOL_SIZE];

   always #1 clock = ~clock;

   fully_associative_tlb dut (
      .clock                (clock),
      .reset                (reset),
      .start                (start),
      .busy                 (busy),
      .req_operation        (req_operation),
      .req_virtual_address  (req_virtual_address),
      .req_fill_page        (req_fill_page),
      .req_fill_frame       (req_fill_frame),
      .req_write_access     (req_write_access),
      .rsp_valid            (rsp_valid),
      .rsp_hit              (rsp_hit),
      .rsp_physical_address (rsp_physical_address)
   );

   fatlb_checker xlat_check (
      .clock                (clock),
      .reset                (reset),
      .start                (start),
      .busy                 (busy),
      .req_operation        (req_operation),
      .req_virtual_address  (req_virtual_address),
      .req_fill_page        (req_fill_page),
      .req_fill_frame       (req_fill_frame),
      .req_write_access     (req_write_access),
      .rsp_valid            (rsp_valid),
      .rsp_hit              (rsp_hit),
      .rsp_physical_address (rsp_physical_address),
      .fail_count           (fail_count),
      .pending              (pending)
   );

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // Called just after a falling edge; returns just after the falling edge
   // that follows the accept, with start still high.
   task automatic send_word(input logic [1:0]                    op,
                            input logic [fatlb_pkg::VA_W-1:0]    va,
                            input logic [fatlb_pkg::PAGE_W-1:0]  page,
                            input logic [fatlb_pkg::FRAME_W-1:0] frame,
                            input logic                          acc);
      start               = 1'b1;
      req_operation       = op;
      req_virtual_address = va;
      req_fill_page       = page;
      req_fill_frame      = frame;
      req_write_access    = acc;
      while (busy) @(negedge clock);
      @(posedge clock);
      @(negedge clock);
   endtask

   task automatic send_random_word();
      int                            pick;
      logic [1:0]                    op;
      logic [fatlb_pkg::VA_W-1:0]    va;
      logic [fatlb_pkg::PAGE_W-1:0]  page;
      logic [fatlb_pkg::FRAME_W-1:0] frame;
      pick  = $urandom_range(0, 99);
      va    = $urandom;
      page  = fatlb_pkg::PAGE_W'($urandom);
      frame = fatlb_pkg::FRAME_W'($urandom);
      if (pick < 50) begin
         op = fatlb_pkg::OP_LOOKUP;
         if ($urandom_range(0, 4) != 0)
            va = {page_pool[$urandom_range(0, POOL_SIZE-1)],
                  va[fatlb_pkg::OFFSET_BITS-1:0]};
      end else if (pick < 93) begin
         op = fatlb_pkg::OP_FILL;
         // mostly a few frames so entries get reused and evicted
         if ($urandom_range(0, 9) < 7)
            frame = fatlb_pkg::FRAME_W'($urandom_range(0, 11));
         if ($urandom_range(0, 9) < 7)
            page = page_pool[$urandom_range(0, POOL_SIZE-1)];
         else
            page_pool[$urandom_range(0, POOL_SIZE-1)] = page;
      end else if (pick < 97) begin
         op = fatlb_pkg::OP_FLUSH;
      end else begin
         op = OP_UNUSED;
      end
      send_word(op, va, page, frame, 1'($urandom_range(0, 1)));
   endtask

   initial begin : stimulus
      int sent;
      int burst;
      int gap;
      for (int i = 0; i < POOL_SIZE; i++)
         page_pool[i] = fatlb_pkg::PAGE_W'($urandom);
      page_pool[0] = '0;
      page_pool[1] = '1;

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // empty buffer misses at both address extremes
      send_word(fatlb_pkg::OP_LOOKUP, 32'h0000_0000, 20'h00000, 8'h00, 1'b0);
      send_word(fatlb_pkg::OP_LOOKUP, 32'hFFFF_FFFF, 20'hFFFFF, 8'hFF, 1'b1);
      send_word(fatlb_pkg::OP_FILL,   32'h0000_0000, 20'h00000, 8'h00, 1'b0);
      send_word(fatlb_pkg::OP_LOOKUP, 32'h0000_0ABC, 20'h00000, 8'h00, 1'b1);
      send_word(fatlb_pkg::OP_FILL,   32'hFFFF_FFFF, 20'hFFFFF, 8'hFF, 1'b1);
      send_word(fatlb_pkg::OP_LOOKUP, 32'hFFFF_FFFF, 20'h00000, 8'h00, 1'b1);
      // same frame again: page of the old entry is replaced
      send_word(fatlb_pkg::OP_FILL,   32'h0000_0000, 20'h12345, 8'h00, 1'b1);
      send_word(fatlb_pkg::OP_LOOKUP, 32'h0000_0123, 20'h00000, 8'h00, 1'b0);
      send_word(fatlb_pkg::OP_LOOKUP, 32'h1234_5678, 20'h00000, 8'h00, 1'b0);
      // second entry for one page: lowest index wins
      send_word(fatlb_pkg::OP_FILL,   32'h0000_0000, 20'hFFFFF, 8'h03, 1'b0);
      send_word(fatlb_pkg::OP_LOOKUP, 32'hFFFF_F000, 20'h00000, 8'h00, 1'b0);
      send_word(OP_UNUSED,            32'hFFFF_FFFF, 20'hFFFFF, 8'hFF, 1'b1);
      // fill the rest; the last fill needs a random victim
      for (int i = 0; i < 6; i++)
         send_word(fatlb_pkg::OP_FILL, 32'h0, fatlb_pkg::PAGE_W'(20'h00100 + i),
                   fatlb_pkg::FRAME_W'(4 + i), i[0]);
      send_word(fatlb_pkg::OP_LOOKUP, 32'h0010_5ABC, 20'h00000, 8'h00, 1'b1);
      send_word(fatlb_pkg::OP_FLUSH,  32'h0000_0000, 20'h00000, 8'h00, 1'b0);
      send_word(fatlb_pkg::OP_LOOKUP, 32'h1234_5678, 20'h00000, 8'h00, 1'b0);
      send_word(fatlb_pkg::OP_FILL,   32'h0000_0000, 20'h00000, 8'h00, 1'b0);
      send_word(fatlb_pkg::OP_LOOKUP, 32'h0000_0FFF, 20'h00000, 8'h00, 1'b1);

      sent = 0;
      while (sent < RANDOM_WORDS) begin
         burst = $urandom_range(1, 24);
         for (int k = 0; k < burst && sent < RANDOM_WORDS; k++) begin
            send_random_word();
            sent++;
         end
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap != 0) begin
            start = 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      start = 1'b0;

      while (pending != 0) @(negedge clock);
      repeat (6) @(negedge clock);
      if (fail_count == 0 && pending == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule

// ===== sim.f =====
src/fatlb_pkg.sv
src/fatlb_search.sv
src/fully_associative_tlb.sv
sim/fatlb_checker.sv
sim/fully_associative_tlb_tb.sv
